@@ hw/rtl/cfar_pkg.sv @@
// cfar_pkg: shared types and constants for the CFAR column detector.
// Holds the detection mode codes, register indexes and the rank stage controls.
// No dependencies.
package cfar_pkg;

    // Detection modes
    typedef enum logic [1:0] {
        MODE_CA = 2'd0,
        MODE_SO = 2'd1,
        MODE_GO = 2'd2,
        MODE_OS = 2'd3
    } t_mode;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK   = 3'd4;

    // Register widths and reset values
    localparam int TRAIN_W  = 5;
    localparam int GUARD_W  = 4;
    localparam int FACTOR_W = 16;
    localparam int RANK_W   = 5;
    localparam logic [TRAIN_W-1:0]  TRAIN_RST  = 5'd8;
    localparam logic [GUARD_W-1:0]  GUARD_RST  = 4'd2;
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 16'd768;
    localparam logic [RANK_W-1:0]   RANK_RST   = 5'd8;

    // Column fill counter saturates here
    localparam int FILL_W = 8;
    localparam logic [FILL_W-1:0] FILL_MAX = 8'd255;

    // Load enables of the two rank-selection stages
    typedef struct packed {
        logic load_cmp;
        logic load_sel;
    } t_rank_ctl;

endpackage

@@ hw/rtl/cfar_rank_sel.sv @@
// cfar_rank_sel: two-stage k-th smallest selection over the training cells.
// Stage one registers the full comparison matrix, stage two counts and picks.
// Depends on cfar_pkg.
module cfar_rank_sel #(
    parameter int N  = 32,
    parameter int SB = 16,
    parameter int CW = 6
) (
    input  logic                  i_clk,
    input  cfar_pkg::t_rank_ctl   i_ctl,
    input  logic [SB-1:0]         i_cells [N],
    input  logic [CW-1:0]         i_count,
    input  logic [CW-1:0]         i_rank,
    output logic [SB-1:0]         o_value
);
    import cfar_pkg::*;

    logic [N-1:0]  r_lt [N];
    logic [N-1:0]  r_le [N];
    logic [N-1:0]  r_act;
    logic [SB-1:0] r_cells [N];
    logic [CW-1:0] r_rank;
    logic [SB-1:0] r_value;

    logic [CW-1:0] c_less [N];
    logic [CW-1:0] c_leq  [N];
    logic [SB-1:0] n_value;

    // Pairwise comparisons, restricted to the active cells
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_cmp) begin
            for (int i = 0; i < N; i++) begin
                r_act[i]   <= (CW'(i) < i_count);
                r_cells[i] <= i_cells[i];
                for (int j = 0; j < N; j++) begin
                    r_lt[i][j] <= (CW'(j) < i_count) && (i_cells[j] <  i_cells[i]);
                    r_le[i][j] <= (CW'(j) < i_count) && (i_cells[j] <= i_cells[i]);
                end
            end
            r_rank <= i_rank;
        end
    end

    // Count per row, then take the first cell whose rank span holds k
    always_comb begin
        logic found;
        found   = 1'b0;
        n_value = '0;
        for (int i = 0; i < N; i++) begin
            c_less[i] = '0;
            c_leq[i]  = '0;
            for (int j = 0; j < N; j++) begin
                c_less[i] = c_less[i] + CW'(r_lt[i][j]);
                c_leq[i]  = c_leq[i]  + CW'(r_le[i][j]);
            end
        end
        for (int i = 0; i < N; i++) begin
            if (!found && r_act[i] && (c_less[i] <= r_rank) && (r_rank < c_leq[i])) begin
                found   = 1'b1;
                n_value = r_cells[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_sel) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

@@ hw/rtl/cfar_column_detector.sv @@
// cfar_column_detector: CA / SO / GO / OS CFAR detector over one sample column.
// Depends on cfar_pkg and cfar_rank_sel.
//
// Usage:
//   Samples enter on the input request channel (i_in_valid / o_in_ready), one
//   row per request; i_column_last marks the final row of a column. Decisions
//   leave on the output channel (o_out_valid / i_out_ready) with the row index,
//   the detect bit and a column_done flag on the last decision of a column.
//   The cell under test trails the newest sample by H = train + guard rows.
//   Registers are written over the cfg channel, which is always ready, and
//   may only change while no request is in flight.
//   A decision passes the window register, cell gather, sums/compare matrix,
//   statistic/scale, then the multiply and compare into the output register.
//   Throughput: one sample per cycle unless stalled or flushing. A column_last
//   request flushes up to H pending rows through the output register, one per
//   cycle when not stalled; the stages behind it hold meanwhile, and the input
//   is held off once they are full.
//   Reset clears the valid flags and the flush, row and fill counts, and sets the
//   registers to their defaults. A stalled receiver holds the output register;
//   the stages behind it keep filling bubbles before the input is held off.
module cfar_column_detector #(
    parameter int MAX_TRAIN_HALF = 16,
    parameter int MAX_GUARD_HALF = 8,
    parameter int SAMPLE_BITS    = 16,
    parameter int MAX_ROWS       = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [SAMPLE_BITS-1:0]              i_sample,
    input  logic                                i_column_last,
    // decision channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [$clog2(MAX_ROWS)-1:0]         o_row_index,
    output logic                                o_detected,
    output logic                                o_column_done,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cfar_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cfar_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import cfar_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int MT   = MAX_TRAIN_HALF;
    localparam int WIN  = 2 * (MAX_TRAIN_HALF + MAX_GUARD_HALF) + 1;
    localparam int NC   = 2 * MAX_TRAIN_HALF;
    localparam int TW   = $clog2(MAX_TRAIN_HALF + 1);
    localparam int GW   = $clog2(MAX_GUARD_HALF + 2);
    localparam int HW   = $clog2(MAX_TRAIN_HALF + MAX_GUARD_HALF + 1);
    localparam int IW   = $clog2(WIN);
    localparam int CW   = $clog2(NC + 1);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int AW   = ((RW > HW) ? RW : HW) + 2;
    localparam int SUMW = SB + $clog2(NC + 1);
    localparam int LW   = SB + 8 + $clog2(NC + 1);
    localparam int PRW  = FACTOR_W + SUMW;

    typedef struct packed {
        logic [RW-1:0] row;
        logic [RW-1:0] n;
        logic [HW-1:0] pending;
        logic          has_main;
        logic          det_ok;
        logic          last;
    } t_meta;

    // ---------------- configuration registers
    t_mode               r_mode;
    logic [TRAIN_W-1:0]  r_train;
    logic [GUARD_W-1:0]  r_guard;
    logic [FACTOR_W-1:0] r_factor;
    logic [RANK_W-1:0]   r_rank;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_CA;
            r_train  <= TRAIN_RST;
            r_guard  <= GUARD_RST;
            r_factor <= FACTOR_RST;
            r_rank   <= RANK_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE:   r_mode   <= t_mode'(i_cfg_data[1:0]);
                CFG_TRAIN:  r_train  <= i_cfg_data[TRAIN_W-1:0];
                CFG_GUARD:  r_guard  <= i_cfg_data[GUARD_W-1:0];
                CFG_FACTOR: r_factor <= i_cfg_data[FACTOR_W-1:0];
                CFG_RANK:   r_rank   <= i_cfg_data[RANK_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective half widths: train 0 counts as 1, both clamp to their maximum
    logic [TW-1:0] c_t;
    logic [GW-1:0] c_g;
    logic [HW-1:0] c_h;
    logic [IW-1:0] c_base;
    logic [CW-1:0] c_n;
    logic [CW-1:0] c_k;

    assign c_t = (r_train == '0) ? TW'(1) :
                 ((32'(r_train) > MAX_TRAIN_HALF) ? TW'(MAX_TRAIN_HALF) : TW'(r_train));
    assign c_g = (32'(r_guard) > MAX_GUARD_HALF) ? GW'(MAX_GUARD_HALF) : GW'(r_guard);
    assign c_h = HW'(c_t) + HW'(c_g);
    assign c_base = IW'(c_t) + IW'(c_g) + IW'(c_g) + IW'(1);
    assign c_n = CW'(c_t) + CW'(c_t);
    assign c_k = (32'(r_rank) >= 32'(c_n)) ? (c_n - CW'(1)) : CW'(r_rank);

    // Row arithmetic modulo MAX_ROWS; d stays below twice MAX_ROWS
    function automatic logic [RW-1:0] row_back(input logic [RW-1:0] n, input logic [HW-1:0] d);
        logic [AW-1:0] dm;
        logic [AW-1:0] nn;
        dm = AW'(d);
        nn = AW'(n);
        if (dm >= AW'(MAX_ROWS)) begin
            dm = dm - AW'(MAX_ROWS);
        end
        if (nn >= dm) begin
            return RW'(nn - dm);
        end
        return RW'(nn + AW'(MAX_ROWS) - dm);
    endfunction

    // ---------------- pipeline control: each stage moves when the next frees up
    logic r_v0, r_v1, r_v2, r_v3;
    logic take0, take1, take2, take3, go4, out_free, flushing;
    logic acc;

    logic          r_ov;
    logic [RW-1:0] r_row;
    logic          r_det;
    logic          r_done;
    logic [HW-1:0] r_fl_cnt;
    logic [RW-1:0] r_fl_n;

    assign flushing   = (r_fl_cnt != '0);
    assign out_free   = !r_ov || i_out_ready;
    assign go4        = out_free && !flushing;
    assign take3      = !r_v3 || go4;
    assign take2      = !r_v2 || take3;
    assign take1      = !r_v1 || take2;
    assign take0      = !r_v0 || take1;
    assign o_in_ready = take0;
    assign acc        = i_in_valid && o_in_ready;

    // ---------------- stage 0: window shift line and column counters
    logic [SB-1:0]     r_window [WIN];
    logic [RW-1:0]     r_rows;
    logic [FILL_W-1:0] r_fill;
    t_meta             r0_meta;

    logic [FILL_W-1:0] c_fill_new;
    logic              c_has_main;
    t_meta             c_meta;

    always_comb begin
        c_fill_new       = (r_fill == FILL_MAX) ? FILL_MAX : r_fill + FILL_W'(1);
        c_has_main       = (32'(c_fill_new) > 32'(c_h));
        c_meta.has_main  = c_has_main;
        c_meta.det_ok    = (32'(c_fill_new) > 2 * 32'(c_h));
        c_meta.pending   = c_has_main ? c_h : HW'(c_fill_new);
        c_meta.last      = i_column_last;
        c_meta.n         = r_rows;
        c_meta.row       = row_back(r_rows, c_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_rows <= '0;
            r_fill <= '0;
        end else begin
            if (take0) begin
                r_v0 <= acc;
            end
            if (acc) begin
                if (i_column_last) begin
                    r_rows <= '0;
                    r_fill <= '0;
                end else begin
                    r_rows <= (32'(r_rows) == MAX_ROWS - 1) ? '0 : r_rows + RW'(1);
                    r_fill <= c_fill_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_window[0] <= i_sample;
            for (int i = 1; i < WIN; i++) begin
                r_window[i] <= r_window[i-1];
            end
            r0_meta <= c_meta;
        end
    end

    // ---------------- stage 1: gather cell under test and training cells
    logic [SB-1:0] c_lag   [MT];
    logic [SB-1:0] c_lead  [MT];
    logic [SB-1:0] c_cells [NC];
    logic [SB-1:0] r1_lag   [MT];
    logic [SB-1:0] r1_lead  [MT];
    logic [SB-1:0] r1_cells [NC];
    logic [SB-1:0] r1_x;
    logic [CW-1:0] r1_n;
    logic [CW-1:0] r1_k;
    t_meta         r1_meta;

    always_comb begin
        for (int i = 0; i < MT; i++) begin
            c_lag[i]  = (i < 32'(c_t)) ? r_window[i] : '0;
            c_lead[i] = (i < 32'(c_t)) ? r_window[IW'(c_base + IW'(i))] : '0;
        end
        for (int i = 0; i < NC; i++) begin
            if (i < 32'(c_t)) begin
                c_cells[i] = r_window[i];
            end else if (i < 32'(c_n)) begin
                c_cells[i] = r_window[IW'(c_base + IW'(i) - IW'(c_t))];
            end else begin
                c_cells[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take1) begin
            r1_lag   <= c_lag;
            r1_lead  <= c_lead;
            r1_cells <= c_cells;
            r1_x     <= r_window[IW'(c_h)];
            r1_n     <= c_n;
            r1_k     <= c_k;
            r1_meta  <= r0_meta;
        end
    end

    // ---------------- stage 2: side sums; rank compare matrix in the submodule
    logic [SUMW-1:0] c_lag_sum, c_lead_sum;
    logic [SUMW-1:0] r2_lag_sum, r2_lead_sum;
    logic [SB-1:0]   r2_x;
    t_meta           r2_meta;

    always_comb begin
        c_lag_sum  = '0;
        c_lead_sum = '0;
        for (int i = 0; i < MT; i++) begin
            c_lag_sum  = c_lag_sum  + SUMW'(r1_lag[i]);
            c_lead_sum = c_lead_sum + SUMW'(r1_lead[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take2) begin
            r2_lag_sum  <= c_lag_sum;
            r2_lead_sum <= c_lead_sum;
            r2_x        <= r1_x;
            r2_meta     <= r1_meta;
        end
    end

    t_rank_ctl     rank_ctl;
    logic [SB-1:0] rank_value;

    assign rank_ctl.load_cmp = take2;
    assign rank_ctl.load_sel = take3;

    cfar_rank_sel #(
        .N  (NC),
        .SB (SB),
        .CW (CW)
    ) u_rank (
        .i_clk   (i_clk),
        .i_ctl   (rank_ctl),
        .i_cells (r1_cells),
        .i_count (r1_n),
        .i_rank  (r1_k),
        .o_value (rank_value)
    );

    // ---------------- stage 3: pick the statistic, scale the cell
    logic [SUMW-1:0] c_stat;
    logic [LW-1:0]   c_xs;
    logic [LW-1:0]   c_lhs;
    logic [SUMW-1:0] r3_stat;
    logic [LW-1:0]   r3_lhs;
    t_meta           r3_meta;

    always_comb begin
        c_xs = LW'(r2_x) << 8;
        case (r_mode)
            MODE_SO: begin
                c_stat = (r2_lead_sum < r2_lag_sum) ? r2_lead_sum : r2_lag_sum;
                c_lhs  = LW'(c_xs * LW'(c_t));
            end
            MODE_GO: begin
                c_stat = (r2_lead_sum > r2_lag_sum) ? r2_lead_sum : r2_lag_sum;
                c_lhs  = LW'(c_xs * LW'(c_t));
            end
            MODE_OS: begin
                c_stat = '0;
                c_lhs  = c_xs;
            end
            default: begin
                c_stat = r2_lead_sum + r2_lag_sum;
                c_lhs  = LW'(c_xs * LW'(c_n));
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take3) begin
            r3_stat <= c_stat;
            r3_lhs  <= c_lhs;
            r3_meta <= r2_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (take1) r_v1 <= r_v0;
            if (take2) r_v2 <= r_v1;
            if (take3) r_v3 <= r_v2;
        end
    end

    // ---------------- stage 4: threshold product, compare, flush sequencer
    logic [SUMW-1:0] c_sel;
    logic [PRW-1:0]  c_prod;
    logic            c_det;
    logic [RW-1:0]   c_fl_row;

    logic          n_ov, n_det, n_done;
    logic [RW-1:0] n_row, n_fl_n;
    logic [HW-1:0] n_fl_cnt;

    assign c_sel    = (r_mode == MODE_OS) ? SUMW'(rank_value) : r3_stat;
    assign c_prod   = PRW'(r_factor) * PRW'(c_sel);
    assign c_det    = r3_meta.det_ok && (PRW'(r3_lhs) > c_prod);
    assign c_fl_row = row_back(r_fl_n, r_fl_cnt - HW'(1));

    always_comb begin
        n_ov     = r_ov;
        n_row    = r_row;
        n_det    = r_det;
        n_done   = r_done;
        n_fl_cnt = r_fl_cnt;
        n_fl_n   = r_fl_n;
        if (out_free) begin
            n_ov = 1'b0;
        end
        if (flushing) begin
            // pending rows of a finished column, all undetected
            if (out_free) begin
                n_ov     = 1'b1;
                n_row    = c_fl_row;
                n_det    = 1'b0;
                n_done   = (r_fl_cnt == HW'(1));
                n_fl_cnt = r_fl_cnt - HW'(1);
            end
        end else if (go4 && r_v3) begin
            if (r3_meta.has_main) begin
                n_ov   = 1'b1;
                n_row  = r3_meta.row;
                n_det  = c_det;
                n_done = 1'b0;
            end
            if (r3_meta.last) begin
                n_fl_cnt = r3_meta.pending;
                n_fl_n   = r3_meta.n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_fl_cnt <= '0;
        end else begin
            r_ov     <= n_ov;
            r_fl_cnt <= n_fl_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_det  <= n_det;
        r_done <= n_done;
        r_fl_n <= n_fl_n;
    end

    assign o_out_valid   = r_ov;
    assign o_row_index   = r_row;
    assign o_detected    = r_det;
    assign o_column_done = r_done;

endmodule

@@ test/cfar_column_detector_tb.sv @@
// cfar_column_detector_tb: self-checking testbench for the CFAR column detector.
// Drives sample columns under several register settings, predicts every decision
// and checks it against the block's output. Depends on cfar_pkg and the RTL.
`timescale 1ns / 100ps

module cfar_column_detector_tb;
    import cfar_pkg::*;

    localparam int  WIN_LEN     = 2 * (16 + 8) + 1;
    localparam int  CYCLE_LIMIT = 100000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic [15:0] sample;
        logic        last;
    } t_sample_req;

    typedef struct {
        logic [11:0] row;
        logic        det;
        logic        done;
    } t_decision;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [15:0] i_sample = '0;
    logic        i_column_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [11:0] o_row_index;
    logic        o_detected;
    logic        o_column_done;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Stimulus and expectation stores
    t_sample_req pending_samples[$];
    t_decision   expected_decisions[$];
    int          mismatches = 0;
    int          decisions_checked = 0;
    int          hits_seen = 0;
    int          samples_sent = 0;
    int          cycle_count = 0;
    logic        allow_idle = 1'b1;
    logic        holdoff_go = 1'b0;
    logic        holdoff_done = 1'b0;
    int          holdoff_cnt = 0;

    // Predictor state
    t_mode       cur_mode;
    logic [4:0]  cur_train;
    logic [3:0]  cur_guard;
    logic [15:0] cur_factor;
    logic [4:0]  cur_rank;
    logic [15:0] win[WIN_LEN];
    logic [11:0] next_row;
    int          col_fill;

    cfar_column_detector u_dut (.*);

    always #10 i_clk = ~i_clk;

    // Append helpers for the two queues
    function automatic void add_expected(t_decision d);
        expected_decisions.insert(expected_decisions.size(), d);
    endfunction

    function automatic void add_sample(logic [15:0] s, logic l);
        t_sample_req r;
        r.sample = s;
        r.last = l;
        pending_samples.insert(pending_samples.size(), r);
    endfunction

    // Threshold test on the current window for the cell H rows back
    function automatic logic cell_hit(int t, int g);
        int         h;
        longint     x, f, lead, lag, s, v, tmp;
        longint     cells[32];
        int         n, k, i, j;
        h = t + g;
        x = win[h];
        f = cur_factor;
        lead = 0;
        lag = 0;
        if (cur_mode == MODE_OS) begin
            n = 2 * t;
            k = (cur_rank >= n) ? n - 1 : cur_rank;
            for (i = 0; i < t; i++) begin
                cells[i] = win[i];
                cells[t + i] = win[h + g + 1 + i];
            end
            // insertion sort, then pick rank k
            for (i = 1; i < n; i++) begin
                tmp = cells[i];
                j = i - 1;
                while (j >= 0 && cells[j] > tmp) begin
                    cells[j + 1] = cells[j];
                    j--;
                end
                cells[j + 1] = tmp;
            end
            v = cells[k];
            return (x * 256 > f * v);
        end
        for (i = 0; i < t; i++) begin
            lag += win[i];
            lead += win[h + g + 1 + i];
        end
        if (cur_mode == MODE_CA)
            return (x * 256 * (2 * t) > f * (lead + lag));
        if (cur_mode == MODE_SO) s = (lead < lag) ? lead : lag;
        else s = (lead > lag) ? lead : lag;
        return (x * 256 * t > f * s);
    endfunction

    // Queue the decisions one accepted sample produces
    task automatic predict_decisions(t_sample_req req);
        int          t, g, h, i, pending;
        logic [11:0] n;
        t_decision   d;
        t = (cur_train == 0) ? 1 : (cur_train > 16) ? 16 : cur_train;
        g = (cur_guard > 8) ? 8 : cur_guard;
        h = t + g;
        n = next_row;
        for (i = WIN_LEN - 1; i > 0; i--) win[i] = win[i - 1];
        win[0] = req.sample;
        next_row = n + 12'd1;
        if (col_fill < 255) col_fill++;
        if (col_fill > h) begin
            d.row = n - 12'(h);
            d.det = (col_fill > 2 * h) ? cell_hit(t, g) : 1'b0;
            d.done = 1'b0;
            add_expected(d);
        end
        if (req.last) begin
            pending = (col_fill > h) ? h : col_fill;
            for (i = pending; i > 0; i--) begin
                d.row = n - 12'(i - 1);
                d.det = 1'b0;
                d.done = (i == 1);
                add_expected(d);
            end
            next_row = '0;
            col_fill = 0;
        end
    endtask

    // Sample driver
    always @(posedge i_clk) begin
        t_sample_req req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                req.sample = i_sample;
                req.last = i_column_last;
                predict_decisions(req);
                samples_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_samples.size() > 0 &&
                    !(allow_idle && $urandom_range(99) < 35)) begin
                    req = pending_samples.pop_front();
                    i_in_valid <= 1'b1;
                    i_sample <= req.sample;
                    i_column_last <= req.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted on its own
    always @(posedge i_clk) begin
        if (holdoff_go && !holdoff_done) begin
            holdoff_cnt <= holdoff_cnt + 1;
            if (holdoff_cnt == 299) holdoff_done <= 1'b1;
        end
    end

    // Decision monitor and receiver stalls
    always @(posedge i_clk) begin
        t_decision e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                decisions_checked++;
                if (o_detected) hits_seen++;
                if (expected_decisions.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected decision row %0d det %0b done %0b",
                                 o_row_index, o_detected, o_column_done);
                end else begin
                    e = expected_decisions.pop_front();
                    if (e.row !== o_row_index || e.det !== o_detected ||
                        e.done !== o_column_done) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"decision mismatch: exp row %0d det %0b done %0b,",
                                      " got row %0d det %0b done %0b"},
                                     e.row, e.det, e.done,
                                     o_row_index, o_detected, o_column_done);
                    end
                end
            end
            if (holdoff_go && !holdoff_done) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= !(allow_idle && $urandom_range(99) < 35);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Register write over the cfg channel; call it just after the clock has risen
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MODE:   cur_mode = t_mode'(value[1:0]);
            CFG_TRAIN:  cur_train = value[4:0];
            CFG_GUARD:  cur_guard = value[3:0];
            CFG_FACTOR: cur_factor = value;
            CFG_RANK:   cur_rank = value[4:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(t_mode m, int t, int g, int f, int k);
        write_reg(CFG_MODE, 16'(m));
        write_reg(CFG_TRAIN, 16'(t));
        write_reg(CFG_GUARD, 16'(g));
        write_reg(CFG_FACTOR, 16'(f));
        write_reg(CFG_RANK, 16'(k));
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every request is through and the flush has settled
    task automatic drain();
        do @(posedge i_clk);
        while (pending_samples.size() > 0 || i_in_valid || expected_decisions.size() > 0);
        repeat (30) @(posedge i_clk);
    endtask

    // Mostly low clutter with occasional strong returns
    function automatic logic [15:0] clutter_sample();
        if ($urandom_range(5) == 0) return 16'($urandom_range(65535));
        return 16'($urandom_range(400));
    endfunction

    task automatic queue_column(int len);
        for (int i = 0; i < len; i++)
            add_sample(clutter_sample(), i == len - 1);
    endtask

    task automatic random_columns(int items);
        int len;
        while (items > 0) begin
            len = $urandom_range(1, 60);
            if (len > items) len = items;
            queue_column(len);
            items -= len;
        end
    endtask

    initial begin
        cur_mode = MODE_CA;
        cur_train = TRAIN_RST;
        cur_guard = GUARD_RST;
        cur_factor = FACTOR_RST;
        cur_rank = RANK_RST;
        foreach (win[i]) win[i] = '0;
        next_row = '0;
        col_fill = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: defaults, extremes, single-row and short columns
        add_sample(16'hFFFF, 1'b1);
        for (int i = 0; i < 20; i++)
            add_sample((i % 2) ? 16'hFFFF : 16'h0000, i == 19);
        queue_column(3);
        drain();
        write_reg(CFG_UNUSED, 16'hFFFF);   // unused index, ignored
        set_regs(MODE_CA, 1, 0, 256, 0);
        for (int i = 0; i < 4; i++) add_sample(16'h0000, 1'b0);
        add_sample(16'hFFFF, 1'b0);
        for (int i = 0; i < 3; i++) add_sample(16'h0001, i == 2);
        drain();

        // Random phases across modes and register extremes
        allow_idle = 1'b0;
        random_columns(25);
        drain();
        allow_idle = 1'b1;
        set_regs(MODE_SO, 16, 8, 65535, 31);
        random_columns(30);
        queue_column(55 - 30);
        drain();
        set_regs(MODE_GO, 0, 15, 300, 0);
        random_columns(25);
        drain();
        set_regs(MODE_OS, 31, 3, 0, 31);
        random_columns(25);
        drain();
        set_regs(MODE_OS, 4, 1, 400, 3);
        random_columns(15);
        holdoff_go <= 1'b1;
        random_columns(30);
        drain();

        $display("ran %0d samples, checked %0d decisions (%0d detections)",
                 samples_sent, decisions_checked, hits_seen);
        $display("covered CA/SO/GO/OS, register extremes, flushes, short columns, stalls");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
